// ===== hw/rtl/ccd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types, codes and constants of the corner candidate dedup block.
// ----------------------------------------------------------------------------
package ccd_pkg;

  // Default sizes of the corner table and of the stored coordinates.
  localparam int MAX_CORNERS_DEF = 64;
  localparam int COORD_BITS_DEF  = 12;
  localparam int COORD_MAX_W     = 16;

  // Fixed field widths.
  localparam int IN_COORD_W  = 12;
  localparam int RADIUS_W    = 8;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int SLOT_W      = 6;
  localparam int COUNT_OUT_W = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;
  localparam int LIM_W       = 2 * RADIUS_W;

  // Signed width that holds any border difference without overflow.
  localparam int BORDER_W = 18;

  // Register values after reset.
  localparam logic [CFG_W-1:0]    FRAME_WIDTH_RST   = 12'd1920;
  localparam logic [CFG_W-1:0]    FRAME_HEIGHT_RST  = 12'd1080;
  localparam logic [RADIUS_W-1:0] CORNER_RADIUS_RST = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_CORNER_RADIUS = 2'd2
  } cfg_index_t;

  typedef enum logic [OUT_TUSER_W-1:0] {
    VERDICT_BORDER = 2'd0,
    VERDICT_NEAR   = 2'd1,
    VERDICT_ACCEPT = 2'd2,
    VERDICT_FULL   = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BORDER,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;    // latch a new candidate and clear the scan
    logic issue;   // read the next table entry
    logic finish;  // write the result and update the table
  } ccd_cmd_t;

  typedef struct packed {
    logic border;     // candidate lies too close to a frame edge
    logic near;       // a stored corner lies within the radius
    logic busy;       // distance pipeline still holds entries
    logic scan_last;  // the entry being read now is the last stored one
    logic empty;      // the table holds no corners
    logic out_free;   // the output register can take a result
  } ccd_status_t;

endpackage

// ===== hw/rtl/ccd_ram.sv =====
// ----------------------------------------------------------------------------
// ccd_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ccd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ccd_datapath.sv =====
// ----------------------------------------------------------------------------
// ccd_datapath
// Configuration registers, corner table, distance pipeline and result
// register of the corner candidate dedup block.
// ----------------------------------------------------------------------------
module ccd_datapath #(
  parameter int MAX_CORNERS = ccd_pkg::MAX_CORNERS_DEF,
  parameter int COORD_BITS  = ccd_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ccd_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            cfg_we,
  input  logic [ccd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccd_pkg::CFG_W-1:0]       cfg_data,
  input  ccd_pkg::ccd_cmd_t               cmd,
  output ccd_pkg::ccd_status_t            status,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ccd_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [ccd_pkg::OUT_TUSER_W-1:0] m_tuser
);

  import ccd_pkg::*;

  localparam int ADDR_W = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
  localparam int CNT_W  = $clog2(MAX_CORNERS + 1);
  localparam int ENT_W  = 2 * COORD_BITS;
  localparam int D_W    = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 1;

  logic [CFG_W-1:0]       frame_width;
  logic [CFG_W-1:0]       frame_height;
  logic [RADIUS_W-1:0]    corner_radius;
  logic [COORD_BITS-1:0]  cur_x;
  logic [COORD_BITS-1:0]  cur_y;
  logic [LIM_W-1:0]       lim;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       scan_idx;
  logic                   v1;
  logic                   v2;
  logic [SQ_W-1:0]        sq_x;
  logic [SQ_W-1:0]        sq_y;
  logic                   near;

  logic [COORD_MAX_W-1:0] ext_x;
  logic [COORD_MAX_W-1:0] ext_y;
  logic [ENT_W-1:0]       rdata;
  logic [COORD_BITS-1:0]  ent_col;
  logic [COORD_BITS-1:0]  ent_row;
  logic signed [D_W-1:0]  dx;
  logic signed [D_W-1:0]  dy;
  logic signed [2*D_W-1:0] px;
  logic signed [2*D_W-1:0] py;
  logic [SUM_W-1:0]       dist_sum;
  logic                   hit;
  logic                   border;
  logic signed [BORDER_W-1:0] bw;
  logic signed [BORDER_W-1:0] bh;
  logic signed [BORDER_W-1:0] bx;
  logic signed [BORDER_W-1:0] by;
  logic signed [BORDER_W-1:0] br;
  verdict_t               verdict;
  logic                   accept;
  logic                   out_free;
  logic [SLOT_W-1:0]      slot_out;
  logic [COUNT_OUT_W-1:0] count_out;

  // Coordinates keep only their low COORD_BITS bits.
  assign ext_x = COORD_MAX_W'(s_tdata[IN_COORD_W-1:0]);
  assign ext_y = COORD_MAX_W'(s_tdata[2*IN_COORD_W-1:IN_COORD_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
      corner_radius <= CORNER_RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:   frame_width   <= cfg_data;
        CFG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        CFG_CORNER_RADIUS: corner_radius <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x <= ext_x[COORD_BITS-1:0];
      cur_y <= ext_y[COORD_BITS-1:0];
      lim   <= LIM_W'(corner_radius) * LIM_W'(corner_radius);
    end
  end

  // Border test in signed arithmetic, wide enough for every difference.
  assign bw = $signed(BORDER_W'(frame_width));
  assign bh = $signed(BORDER_W'(frame_height));
  assign bx = $signed(BORDER_W'(cur_x));
  assign by = $signed(BORDER_W'(cur_y));
  assign br = $signed(BORDER_W'(corner_radius));
  assign border = (bw - bx < br) || (bh - by < br) || (bx < br) || (by < br);

  ccd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_CORNERS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.finish && accept),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({cur_y, cur_x}),
    .raddr (scan_idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign ent_col = rdata[COORD_BITS-1:0];
  assign ent_row = rdata[ENT_W-1:COORD_BITS];
  assign dx = $signed({1'b0, ent_col}) - $signed({1'b0, cur_x});
  assign dy = $signed({1'b0, ent_row}) - $signed({1'b0, cur_y});
  assign px = (2*D_W)'(dx) * (2*D_W)'(dx);
  assign py = (2*D_W)'(dy) * (2*D_W)'(dy);

  // Pipeline: table read, squares, then sum and compare against r*r.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    sq_x <= px[SQ_W-1:0];
    sq_y <= py[SQ_W-1:0];
  end

  assign dist_sum = {1'b0, sq_x} + {1'b0, sq_y};
  assign hit      = v2 && (dist_sum < SUM_W'(lim));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      near     <= 1'b0;
    end else if (cmd.load) begin
      scan_idx <= '0;
      near     <= 1'b0;
    end else begin
      if (cmd.issue) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (hit) begin
        near <= 1'b1;
      end
    end
  end

  always_comb begin
    if (border) begin
      verdict = VERDICT_BORDER;
    end else if (near) begin
      verdict = VERDICT_NEAR;
    end else if (count >= CNT_W'(MAX_CORNERS)) begin
      verdict = VERDICT_FULL;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
  end

  assign accept    = (verdict == VERDICT_ACCEPT);
  assign slot_out  = accept ? SLOT_W'(count) : '0;
  assign count_out = accept ? COUNT_OUT_W'(count + CNT_W'(1)) : COUNT_OUT_W'(count);
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
      if (accept) begin
        count <= count + CNT_W'(1);
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= OUT_TDATA_W'({count_out, slot_out});
      m_tuser <= verdict;
    end
  end

  always_comb begin
    status.border    = border;
    status.near      = near;
    status.busy      = v1 || v2;
    status.scan_last = (scan_idx + CNT_W'(1) == count);
    status.empty     = (count == '0);
    status.out_free  = out_free;
  end

endmodule

// ===== hw/rtl/ccd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccd_ctrl
// Sequencer that walks one candidate through the border test, the table
// scan and the result write.
// ----------------------------------------------------------------------------
module ccd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  ccd_pkg::ccd_status_t status,
  output ccd_pkg::ccd_cmd_t    cmd
);

  import ccd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_BORDER;
        end
      end
      ST_BORDER: begin
        if (status.border || status.empty) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // A hit ends the scan early; entries still in flight are ignored.
        if (status.near) begin
          state_next = ST_DONE;
        end else if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.near || !status.busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // No item is taken while reset is held.
  always_comb begin
    s_tready   = (state == ST_IDLE) && !rst;
    cmd.load   = (state == ST_IDLE) && !rst && s_tvalid;
    cmd.issue  = (state == ST_SCAN);
    cmd.finish = (state == ST_DONE) && status.out_free;
  end

endmodule

// ===== hw/rtl/corner_candidate_dedup.sv =====
// ----------------------------------------------------------------------------
// corner_candidate_dedup
// Radius-based suppression of corner candidates against a table of stored
// corners.
// ----------------------------------------------------------------------------
// A candidate is accepted only while the block is idle, so a new one waits until
// the previous result is written. The table scan reads one stored entry a cycle
// into the shared distance pipeline and ends early on a hit; a border reject or
// an empty table skips the scan.
// Reset (rst, synchronous) empties the table and restores the register
// defaults; the table contents themselves are not cleared.
module corner_candidate_dedup #(
  parameter int MAX_CORNERS = ccd_pkg::MAX_CORNERS_DEF,
  parameter int COORD_BITS  = ccd_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ccd_pkg::IN_TDATA_W-1:0]  s_tdata,   // cand_x, cand_y
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ccd_pkg::OUT_TDATA_W-1:0] m_tdata,   // slot, corner_count
  output logic [ccd_pkg::OUT_TUSER_W-1:0] m_tuser,   // verdict
  input  logic                            cfg_we,
  input  logic [ccd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccd_pkg::CFG_W-1:0]       cfg_data
);

  import ccd_pkg::*;

  ccd_cmd_t    cmd;
  ccd_status_t status;

  ccd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ccd_datapath #(
    .MAX_CORNERS (MAX_CORNERS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== hw/rtl/ccd_checker.sv =====
// ----------------------------------------------------------------------------
// ccd_checker
// Port-level checks of the corner candidate dedup block, bound to the top.
// ----------------------------------------------------------------------------
module ccd_checker #(
  parameter int MAX_CORNERS = ccd_pkg::MAX_CORNERS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ccd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [ccd_pkg::OUT_TUSER_W-1:0] m_tuser
);

  import ccd_pkg::*;

  logic [SLOT_W-1:0]      slot_f;
  logic [COUNT_OUT_W-1:0] count_f;

  assign slot_f  = m_tdata[SLOT_W-1:0];
  assign count_f = m_tdata[SLOT_W+COUNT_OUT_W-1:SLOT_W];

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Only an accepted candidate reports a table slot.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != VERDICT_ACCEPT) |-> slot_f == '0)
    else $error("slot set on a rejected item");

  // An accepted candidate reports a corner count one past its slot.
  a_accept_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == VERDICT_ACCEPT) && (MAX_CORNERS <= 64)
    |-> count_f == COUNT_OUT_W'({1'b0, slot_f} + 7'd1))
    else $error("corner count does not follow slot");

endmodule

bind corner_candidate_dedup ccd_checker #(
  .MAX_CORNERS (MAX_CORNERS)
) u_ccd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
